>>> hw/rtl/csc_pkg.sv
// Shared widths, pipeline depths, word structs and the saturation helper
// for the circle/segment collision pipeline. No dependencies.
package csc_pkg;

  localparam int COORD_W  = 16;             // coordinate / velocity word
  localparam int RAD_W    = 15;             // radius word
  localparam int DIF_W    = COORD_W + 1;    // coordinate differences
  localparam int LEN_W    = 34;             // squared segment length
  localparam int NUM_W    = 52;             // signed divider numerator
  localparam int QUO_W    = 18;             // quotient magnitude bits
  localparam int SQ_FRAC  = 14;             // fraction bits of the root
  localparam int SQ_IN_W  = LEN_W + 2 * SQ_FRAC;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_LAT   = SQ_OUT_W;       // one root bit per stage
  localparam int DIV_LAT  = QUO_W + 2;      // prep, one bit per stage, sign
  localparam int SUM_W    = QUO_W + 3;      // final centre sum

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Fields that bypass the math and select the result
  typedef struct packed {
    logic                      hit;
    logic                      csign;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
  } side_t;

  // Word waiting for the square root
  typedef struct packed {
    side_t                   side;
    logic [LEN_W-1:0]        len;
    logic signed [NUM_W-1:0] nvx_n;
    logic signed [NUM_W-1:0] nvy_n;
    logic signed [NUM_W-1:0] ncx_n;
    logic signed [NUM_W-1:0] ncy_n;
    logic signed [NUM_W-1:0] pushx_n;
    logic signed [NUM_W-1:0] pushy_n;
  } mid_t;

  // Clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > SAT_HI) begin
      res = COORD_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      res = COORD_W'(SAT_LO);
    end else begin
      res = COORD_W'(v);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/csc_div.sv
// Pipelined restoring divider with round-to-nearest, ties away from zero.
// Uses csc_pkg for widths.
module csc_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [csc_pkg::NUM_W-1:0] num,
  input  logic [csc_pkg::LEN_W-1:0]        den,
  output logic signed [csc_pkg::QUO_W:0]   quo
);

  logic [csc_pkg::NUM_W-1:0] rem_r   [csc_pkg::QUO_W];
  logic [csc_pkg::LEN_W-1:0] den_r   [csc_pkg::QUO_W];
  logic [csc_pkg::QUO_W-1:0] quo_r   [csc_pkg::QUO_W];
  logic                      qneg_r  [csc_pkg::QUO_W];
  logic                      neg0_r;
  logic signed [csc_pkg::QUO_W:0] quo_out_r;

  logic [csc_pkg::NUM_W-1:0] mag_nxt;
  logic [csc_pkg::NUM_W-1:0] trial [csc_pkg::QUO_W];
  logic                      take  [csc_pkg::QUO_W];

  // Magnitude plus half the divisor gives rounding by truncation
  assign mag_nxt = (num[csc_pkg::NUM_W-1] ? csc_pkg::NUM_W'(-num) : csc_pkg::NUM_W'(num))
                 + csc_pkg::NUM_W'(den >> 1);

  // Trial subtract per quotient bit
  always_comb begin
    for (int s = 0; s < csc_pkg::QUO_W; s++) begin
      trial[s] = csc_pkg::NUM_W'(den_r[s]) << (csc_pkg::QUO_W - 1 - s);
      take[s]  = rem_r[s] >= trial[s];
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= mag_nxt;
      den_r[0]  <= den;
      neg0_r    <= num[csc_pkg::NUM_W-1];
      quo_r[0]  <= csc_pkg::QUO_W'(take[0]) << (csc_pkg::QUO_W - 1);
      qneg_r[0] <= neg0_r;
      for (int s = 1; s < csc_pkg::QUO_W; s++) begin
        quo_r[s]  <= quo_r[s-1] | (csc_pkg::QUO_W'(take[s]) << (csc_pkg::QUO_W - 1 - s));
        qneg_r[s] <= qneg_r[s-1];
      end
      for (int s = 0; s < csc_pkg::QUO_W - 1; s++) begin
        rem_r[s+1] <= take[s] ? rem_r[s] - trial[s] : rem_r[s];
        den_r[s+1] <= den_r[s];
      end
      // Apply sign
      quo_out_r <= qneg_r[csc_pkg::QUO_W-1] ? -$signed({1'b0, quo_r[csc_pkg::QUO_W-1]})
                                             :  $signed({1'b0, quo_r[csc_pkg::QUO_W-1]});
    end
  end

  assign quo = quo_out_r;

endmodule

>>> hw/rtl/csc_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor).
// Uses csc_pkg for widths.
module csc_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [csc_pkg::SQ_IN_W-1:0]   x,
  output logic [csc_pkg::SQ_OUT_W-1:0]  root
);

  logic [csc_pkg::SQ_IN_W-1:0]  rem_r  [csc_pkg::SQ_OUT_W-1];
  logic [csc_pkg::SQ_OUT_W-1:0] root_r [csc_pkg::SQ_OUT_W];

  logic [csc_pkg::SQ_IN_W-1:0]  rem_in  [csc_pkg::SQ_OUT_W];
  logic [csc_pkg::SQ_OUT_W-1:0] root_in [csc_pkg::SQ_OUT_W];
  logic [csc_pkg::SQ_IN_W-1:0]  trial   [csc_pkg::SQ_OUT_W];
  logic                         take    [csc_pkg::SQ_OUT_W];

  // Trial value (2*root + 2^k) * 2^k per stage
  always_comb begin
    for (int s = 0; s < csc_pkg::SQ_OUT_W; s++) begin
      if (s == 0) begin
        rem_in[s]  = x;
        root_in[s] = '0;
      end else begin
        rem_in[s]  = rem_r[s-1];
        root_in[s] = root_r[s-1];
      end
      trial[s] = (csc_pkg::SQ_IN_W'(root_in[s]) << (csc_pkg::SQ_OUT_W - s))
               | (csc_pkg::SQ_IN_W'(1) << (2 * (csc_pkg::SQ_OUT_W - 1 - s)));
      take[s]  = rem_in[s] >= trial[s];
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < csc_pkg::SQ_OUT_W; s++) begin
        root_r[s] <= root_in[s]
                   | (csc_pkg::SQ_OUT_W'(take[s]) << (csc_pkg::SQ_OUT_W - 1 - s));
      end
      for (int s = 0; s < csc_pkg::SQ_OUT_W - 1; s++) begin
        rem_r[s] <= take[s] ? rem_in[s] - trial[s] : rem_in[s];
      end
    end
  end

  assign root = root_r[csc_pkg::SQ_OUT_W-1];

endmodule

>>> hw/rtl/circle_segment_collision.sv
// Circle against line segment collision test and response, Q11.4 in and out.
// One word enters per cycle while the pipeline advances. Each word passes
// through the stages of products and sums, the pipelined square root of the
// squared segment length, the rounding dividers and one output register.
// The whole pipeline holds while a result waits under out_stall.
// Depends on csc_pkg, csc_sqrt and csc_div.
module circle_segment_collision (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [csc_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [csc_pkg::COORD_W-1:0] in_center_y,
  input  logic signed [csc_pkg::COORD_W-1:0] in_vel_x,
  input  logic signed [csc_pkg::COORD_W-1:0] in_vel_y,
  input  logic [csc_pkg::RAD_W-1:0]          in_radius,
  input  logic signed [csc_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [csc_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [csc_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [csc_pkg::COORD_W-1:0] in_end_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic signed [csc_pkg::COORD_W-1:0] out_new_vel_x,
  output logic signed [csc_pkg::COORD_W-1:0] out_new_vel_y,
  output logic signed [csc_pkg::COORD_W-1:0] out_new_center_x,
  output logic signed [csc_pkg::COORD_W-1:0] out_new_center_y
);

  localparam int PIPE_LEN = 5 + csc_pkg::SQ_LAT + csc_pkg::DIV_LAT;
  localparam int CW = csc_pkg::COORD_W;
  localparam int DW = csc_pkg::DIF_W;
  localparam int LW = csc_pkg::LEN_W;
  localparam int NW = csc_pkg::NUM_W;
  localparam int RW = csc_pkg::RAD_W;
  localparam int SW = csc_pkg::SUM_W;

  logic adv;
  logic [PIPE_LEN-1:0] vpipe_r;
  logic out_valid_r;

  // Stage 1: differences
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_gx_r, s1_gy_r, s1_mx_r;
  logic signed [CW-1:0] s1_vx_r, s1_vy_r, s1_px_r, s1_py_r, s1_sx_r, s1_sy_r;
  logic [RW-1:0]        s1_r_r;
  // Stage 2: products
  logic signed [2*DW-1:0] s2_gxgx_r, s2_gygy_r, s2_dxgx_r, s2_dygy_r, s2_mxdx_r, s2_mydy_r;
  logic signed [CW+DW-1:0] s2_vxmx_r, s2_vymy_r;
  logic [2*RW-1:0]        s2_rr_r;
  logic signed [DW-1:0]   s2_gx_r, s2_gy_r, s2_mx_r;
  logic signed [CW-1:0]   s2_vx_r, s2_vy_r, s2_px_r, s2_py_r, s2_sx_r, s2_sy_r;
  logic [RW-1:0]          s2_r_r;
  // Stage 3: dot products
  logic [LW-1:0]          s3_len_r, s3_cabs_r;
  logic signed [LW:0]     s3_t_r, s3_c_r;
  logic signed [LW-1:0]   s3_k_r;
  logic [2*RW-1:0]        s3_rr_r;
  logic signed [DW-1:0]   s3_gx_r, s3_gy_r, s3_mx_r;
  logic signed [CW-1:0]   s3_vx_r, s3_vy_r, s3_px_r, s3_py_r, s3_sx_r, s3_sy_r;
  logic [RW-1:0]          s3_r_r;
  logic signed [LW:0]     s3_t_nxt, s3_c_nxt;
  // Stage 4: wide products
  logic                   s4_cond_r, s4_csign_r;
  logic [2*DW-1:0]        s4_chh_r, s4_chl_r, s4_cll_r;
  logic [2*RW+DW-1:0]     s4_rlh_r, s4_rll_r;
  logic signed [CW+LW:0]  s4_vxl_r, s4_vyl_r;
  logic signed [LW+DW-1:0] s4_kmx_r, s4_kmy_r;
  logic signed [NW-1:0]   s4_gxt_r, s4_gyt_r;
  logic signed [CW+DW-1:0] s4_rmx_r, s4_rmy_r;
  logic [LW-1:0]          s4_len_r;
  logic signed [CW-1:0]   s4_vx_r, s4_vy_r, s4_px_r, s4_py_r, s4_sx_r, s4_sy_r;
  // Stage 5: hit decision and numerators
  csc_pkg::mid_t          s5_r, s5_nxt;
  logic [2*LW-1:0]        c2_nxt, rl2_nxt;
  // Square root and delay beside it
  csc_pkg::mid_t          msq_r [csc_pkg::SQ_LAT];
  logic [csc_pkg::SQ_OUT_W-1:0] root;
  csc_pkg::mid_t          mq;
  // Divider side delay and quotients
  csc_pkg::side_t         sd_r [csc_pkg::DIV_LAT];
  csc_pkg::side_t         sd;
  logic signed [csc_pkg::QUO_W:0] q_nvx, q_nvy, q_cx, q_cy, q_px, q_py;
  // Output
  logic                   hit_r;
  logic signed [CW-1:0]   nvx_r, nvy_r, ncx_r, ncy_r;
  logic signed [SW-1:0]   ncx_sum_nxt, ncy_sum_nxt;

  // Move the whole pipe unless a held result is stalled
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Track valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vpipe_r     <= {vpipe_r[PIPE_LEN-2:0], in_valid};
      out_valid_r <= vpipe_r[PIPE_LEN-1];
    end
  end

  // Stage 1: offsets from the segment start
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= DW'(in_center_x) - DW'(in_start_x);
      s1_dy_r <= DW'(in_center_y) - DW'(in_start_y);
      s1_gx_r <= DW'(in_end_x) - DW'(in_start_x);
      s1_gy_r <= DW'(in_end_y) - DW'(in_start_y);
      s1_mx_r <= DW'(in_start_y) - DW'(in_end_y);
      s1_vx_r <= in_vel_x;
      s1_vy_r <= in_vel_y;
      s1_px_r <= in_center_x;
      s1_py_r <= in_center_y;
      s1_sx_r <= in_start_x;
      s1_sy_r <= in_start_y;
      s1_r_r  <= in_radius;
    end
  end

  // Stage 2: narrow products
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_gxgx_r <= s1_gx_r * s1_gx_r;
      s2_gygy_r <= s1_gy_r * s1_gy_r;
      s2_dxgx_r <= s1_dx_r * s1_gx_r;
      s2_dygy_r <= s1_dy_r * s1_gy_r;
      s2_mxdx_r <= s1_mx_r * s1_dx_r;
      s2_mydy_r <= s1_gx_r * s1_dy_r;
      s2_vxmx_r <= s1_vx_r * s1_mx_r;
      s2_vymy_r <= s1_vy_r * s1_gx_r;
      s2_rr_r   <= s1_r_r * s1_r_r;
      s2_gx_r   <= s1_gx_r;
      s2_gy_r   <= s1_gy_r;
      s2_mx_r   <= s1_mx_r;
      s2_vx_r   <= s1_vx_r;
      s2_vy_r   <= s1_vy_r;
      s2_px_r   <= s1_px_r;
      s2_py_r   <= s1_py_r;
      s2_sx_r   <= s1_sx_r;
      s2_sy_r   <= s1_sy_r;
      s2_r_r    <= s1_r_r;
    end
  end

  // Stage 3: length, projection, cross and velocity dot products
  assign s3_t_nxt = (LW+1)'(s2_dxgx_r) + (LW+1)'(s2_dygy_r);
  assign s3_c_nxt = (LW+1)'(s2_mxdx_r) + (LW+1)'(s2_mydy_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_len_r  <= LW'(s2_gxgx_r + s2_gygy_r);
      s3_t_r    <= s3_t_nxt;
      s3_c_r    <= s3_c_nxt;
      s3_cabs_r <= LW'(s3_c_nxt[LW] ? -s3_c_nxt : s3_c_nxt);
      s3_k_r    <= LW'(s2_vxmx_r) + LW'(s2_vymy_r);
      s3_rr_r   <= s2_rr_r;
      s3_gx_r   <= s2_gx_r;
      s3_gy_r   <= s2_gy_r;
      s3_mx_r   <= s2_mx_r;
      s3_vx_r   <= s2_vx_r;
      s3_vy_r   <= s2_vy_r;
      s3_px_r   <= s2_px_r;
      s3_py_r   <= s2_py_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
      s3_r_r    <= s2_r_r;
    end
  end

  // Stage 4: range checks and split wide products
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cond_r  <= (s3_len_r != '0) && (s3_c_r != '0) && !s3_t_r[LW] && (s3_t_r != '0)
                 && (s3_t_r < $signed({1'b0, s3_len_r}));
      s4_csign_r <= s3_c_r[LW];
      s4_chh_r   <= s3_cabs_r[LW-1:DW] * s3_cabs_r[LW-1:DW];
      s4_chl_r   <= s3_cabs_r[LW-1:DW] * s3_cabs_r[DW-1:0];
      s4_cll_r   <= s3_cabs_r[DW-1:0] * s3_cabs_r[DW-1:0];
      s4_rlh_r   <= s3_rr_r * s3_len_r[LW-1:DW];
      s4_rll_r   <= s3_rr_r * s3_len_r[DW-1:0];
      s4_vxl_r   <= s3_vx_r * $signed({1'b0, s3_len_r});
      s4_vyl_r   <= s3_vy_r * $signed({1'b0, s3_len_r});
      s4_kmx_r   <= s3_k_r * s3_mx_r;
      s4_kmy_r   <= s3_k_r * s3_gx_r;
      s4_gxt_r   <= s3_gx_r * s3_t_r;
      s4_gyt_r   <= s3_gy_r * s3_t_r;
      s4_rmx_r   <= $signed({1'b0, s3_r_r}) * s3_mx_r;
      s4_rmy_r   <= $signed({1'b0, s3_r_r}) * s3_gx_r;
      s4_len_r   <= s3_len_r;
      s4_vx_r    <= s3_vx_r;
      s4_vy_r    <= s3_vy_r;
      s4_px_r    <= s3_px_r;
      s4_py_r    <= s3_py_r;
      s4_sx_r    <= s3_sx_r;
      s4_sy_r    <= s3_sy_r;
    end
  end

  // Stage 5: compare cross squared against radius squared times length
  always_comb begin
    c2_nxt  = ((2*LW)'(s4_chh_r) << (2*DW)) + ((2*LW)'(s4_chl_r) << (DW+1))
            + (2*LW)'(s4_cll_r);
    rl2_nxt = ((2*LW)'(s4_rlh_r) << DW) + (2*LW)'(s4_rll_r);
    s5_nxt.side.hit   = s4_cond_r && (c2_nxt <= rl2_nxt);
    s5_nxt.side.csign = s4_csign_r;
    s5_nxt.side.vx    = s4_vx_r;
    s5_nxt.side.vy    = s4_vy_r;
    s5_nxt.side.px    = s4_px_r;
    s5_nxt.side.py    = s4_py_r;
    s5_nxt.side.sx    = s4_sx_r;
    s5_nxt.side.sy    = s4_sy_r;
    s5_nxt.len        = s4_len_r;
    s5_nxt.nvx_n      = NW'(s4_vxl_r) - (NW'(s4_kmx_r) <<< 1);
    s5_nxt.nvy_n      = NW'(s4_vyl_r) - (NW'(s4_kmy_r) <<< 1);
    s5_nxt.ncx_n      = s4_gxt_r;
    s5_nxt.ncy_n      = s4_gyt_r;
    s5_nxt.pushx_n    = NW'(s4_rmx_r) <<< csc_pkg::SQ_FRAC;
    s5_nxt.pushy_n    = NW'(s4_rmy_r) <<< csc_pkg::SQ_FRAC;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r <= s5_nxt;
    end
  end

  // Root of the scaled squared length
  csc_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    ({s5_r.len, (2*csc_pkg::SQ_FRAC)'(0)}),
    .root (root)
  );

  // Hold the word beside the root
  always_ff @(posedge clk) begin
    if (adv) begin
      msq_r[0] <= s5_r;
      for (int i = 1; i < csc_pkg::SQ_LAT; i++) begin
        msq_r[i] <= msq_r[i-1];
      end
    end
  end

  assign mq = msq_r[csc_pkg::SQ_LAT-1];

  // Six rounding divisions
  csc_div u_div_nvx (.clk(clk), .en(adv), .num(mq.nvx_n),   .den(mq.len), .quo(q_nvx));
  csc_div u_div_nvy (.clk(clk), .en(adv), .num(mq.nvy_n),   .den(mq.len), .quo(q_nvy));
  csc_div u_div_cx  (.clk(clk), .en(adv), .num(mq.ncx_n),   .den(mq.len), .quo(q_cx));
  csc_div u_div_cy  (.clk(clk), .en(adv), .num(mq.ncy_n),   .den(mq.len), .quo(q_cy));
  csc_div u_div_px  (.clk(clk), .en(adv), .num(mq.pushx_n), .den(LW'(root)), .quo(q_px));
  csc_div u_div_py  (.clk(clk), .en(adv), .num(mq.pushy_n), .den(LW'(root)), .quo(q_py));

  // Hold pass-through fields beside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= mq.side;
      for (int i = 1; i < csc_pkg::DIV_LAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  assign sd = sd_r[csc_pkg::DIV_LAT-1];

  // Projected point plus signed push-out
  assign ncx_sum_nxt = SW'(sd.sx) + SW'(q_cx) + (sd.csign ? -SW'(q_px) : SW'(q_px));
  assign ncy_sum_nxt = SW'(sd.sy) + SW'(q_cy) + (sd.csign ? -SW'(q_py) : SW'(q_py));

  // Output register: select response or pass-through
  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= sd.hit;
      if (sd.hit) begin
        nvx_r <= csc_pkg::sat_coord(SW'(q_nvx));
        nvy_r <= csc_pkg::sat_coord(SW'(q_nvy));
        ncx_r <= csc_pkg::sat_coord(ncx_sum_nxt);
        ncy_r <= csc_pkg::sat_coord(ncy_sum_nxt);
      end else begin
        nvx_r <= sd.vx;
        nvy_r <= sd.vy;
        ncx_r <= sd.px;
        ncy_r <= sd.py;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_new_vel_x    = nvx_r;
  assign out_new_vel_y    = nvy_r;
  assign out_new_center_x = ncx_r;
  assign out_new_center_y = ncy_r;

endmodule

>>> tb/sv/tb_circle_segment_collision.sv
// Self-checking testbench for circle_segment_collision: queue-fed driver,
// clocked monitor and a bit-exact predictor of the collision response.
// Depends on csc_pkg and the circle_segment_collision RTL.
module tb_circle_segment_collision;

  localparam int LATENCY = 57;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [csc_pkg::COORD_W-1:0] cx, cy, vx, vy, sx, sy, ex, ey;
    logic [csc_pkg::RAD_W-1:0]          rad;
  } ball_word_t;

  typedef struct {
    logic                               hit;
    logic signed [csc_pkg::COORD_W-1:0] nvx, nvy, ncx, ncy;
  } response_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [csc_pkg::COORD_W-1:0] in_center_x = 0, in_center_y = 0;
  logic signed [csc_pkg::COORD_W-1:0] in_vel_x = 0, in_vel_y = 0;
  logic [csc_pkg::RAD_W-1:0] in_radius = 0;
  logic signed [csc_pkg::COORD_W-1:0] in_start_x = 0, in_start_y = 0;
  logic signed [csc_pkg::COORD_W-1:0] in_end_x = 0, in_end_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit;
  logic signed [csc_pkg::COORD_W-1:0] out_new_vel_x, out_new_vel_y;
  logic signed [csc_pkg::COORD_W-1:0] out_new_center_x, out_new_center_y;

  ball_word_t pending_words[$];
  response_t  expected_responses[$];
  int  idle_pct = 0, stall_pct = 0;
  bit  hold_off = 0;
  int  mismatches = 0, checked = 0, hits_seen = 0;
  longint cycles = 0;

  circle_segment_collision dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic signed [csc_pkg::COORD_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[csc_pkg::COORD_W-1:0];
  endfunction

  function automatic longint root_floor(logic [127:0] x);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Compute the collision response for one word
  function automatic response_t predict_bounce(ball_word_t w);
    response_t r;
    longint dx, dy, gx, gy, mx, my, len2, proj, crs, k, q, sg, rr;
    logic signed [127:0] lhs, rhs;
    rr = w.rad;
    dx = w.cx - w.sx; dy = w.cy - w.sy;
    gx = w.ex - w.sx; gy = w.ey - w.sy;
    mx = -gy; my = gx;
    len2 = gx * gx + gy * gy;
    proj = dx * gx + dy * gy;
    crs = mx * dx + my * dy;
    r.hit = 0;
    if (len2 != 0 && crs != 0 && proj > 0 && proj < len2) begin
      lhs = 128'(crs) * 128'(crs);
      rhs = 128'(rr * rr) * 128'(len2);
      r.hit = (lhs <= rhs);
    end
    if (!r.hit) begin
      r.nvx = w.vx; r.nvy = w.vy; r.ncx = w.cx; r.ncy = w.cy;
    end else begin
      k = w.vx * mx + w.vy * my;
      r.nvx = clamp16(round_div(w.vx * len2 - 2 * k * mx, len2));
      r.nvy = clamp16(round_div(w.vy * len2 - 2 * k * my, len2));
      q = root_floor(128'(len2) << 28);
      sg = (crs < 0) ? -1 : 1;
      r.ncx = clamp16(w.sx + round_div(gx * proj, len2) + sg * round_div(rr * mx * 16384, q));
      r.ncy = clamp16(w.sy + round_div(gy * proj, len2) + sg * round_div(rr * my * 16384, q));
    end
    return r;
  endfunction

  function automatic logic signed [csc_pkg::COORD_W-1:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return 16'($urandom);
      default: return $signed(16'($urandom_range(0, 1600))) - 16'sd800;
    endcase
  endfunction

  // Word near a segment so most of them land in the interesting region
  function automatic ball_word_t rnd_word();
    ball_word_t w;
    int t;
    w.sx = rnd_coord(); w.sy = rnd_coord();
    w.ex = rnd_coord(); w.ey = rnd_coord();
    w.vx = 16'($urandom); w.vy = 16'($urandom);
    t = $urandom_range(0, 3);
    if (t != 0) begin
      w.cx = 16'((17'(w.sx) + 17'(w.ex)) / 2)
           + $signed(16'($urandom_range(0, 400))) - 16'sd200;
      w.cy = 16'((17'(w.sy) + 17'(w.ey)) / 2)
           + $signed(16'($urandom_range(0, 400))) - 16'sd200;
      w.rad = 15'($urandom_range(0, 600));
    end else begin
      w.cx = rnd_coord(); w.cy = rnd_coord();
      w.rad = 15'($urandom);
    end
    if ($urandom_range(0, 9) == 0) w.vx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return w;
  endfunction

  function automatic ball_word_t mk(int cx, int cy, int vx, int vy, int rad,
                                    int sx, int sy, int ex, int ey);
    ball_word_t w;
    w.cx = 16'(cx); w.cy = 16'(cy); w.vx = 16'(vx); w.vy = 16'(vy); w.rad = 15'(rad);
    w.sx = 16'(sx); w.sy = 16'(sy); w.ex = 16'(ex); w.ey = 16'(ey);
    return w;
  endfunction

  // Drive the input channel from the pending queue
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!in_valid || !in_stall) begin
      if (rst_n && !hold_off && pending_words.size() != 0 &&
          $urandom_range(0, 99) >= idle_pct) begin
        ball_word_t w;
        w = pending_words.pop_front();
        expected_responses.push_back(predict_bounce(w));
        in_valid <= 1;
        in_center_x <= w.cx; in_center_y <= w.cy;
        in_vel_x <= w.vx; in_vel_y <= w.vy; in_radius <= w.rad;
        in_start_x <= w.sx; in_start_y <= w.sy;
        in_end_x <= w.ex; in_end_y <= w.ey;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      response_t e;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        e = expected_responses.pop_front();
        checked++;
        if (out_hit) hits_seen++;
        if (out_hit !== e.hit || out_new_vel_x !== e.nvx || out_new_vel_y !== e.nvy ||
            out_new_center_x !== e.ncx || out_new_center_y !== e.ncy) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch word %0d: exp hit=%0d v=(%0d,%0d) c=(%0d,%0d)",
                      " got hit=%0d v=(%0d,%0d) c=(%0d,%0d)"},
                     checked, e.hit, e.nvx, e.nvy, e.ncx, e.ncy, out_hit,
                     out_new_vel_x, out_new_vel_y, out_new_center_x, out_new_center_y);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_responses.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // Directed words: extremes and each special case
    pending_words.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));                  // zero length
    pending_words.push_back(mk(50, 0, 10, 20, 100, 0, 0, 100, 0));           // centre on line
    pending_words.push_back(mk(50, 30, 10, -20, 40, 0, 0, 100, 0));          // plain hit
    pending_words.push_back(mk(50, -30, 10, 20, 40, 0, 0, 100, 0));          // hit other side
    pending_words.push_back(mk(0, 30, 10, 20, 40, 0, 0, 100, 0));            // at start point
    pending_words.push_back(mk(100, 30, 10, 20, 40, 0, 0, 100, 0));          // at end point
    pending_words.push_back(mk(150, 30, 10, 20, 40, 0, 0, 100, 0));          // beyond end
    pending_words.push_back(mk(50, 30, 10, 20, 30, 0, 0, 100, 0));           // touching
    pending_words.push_back(mk(50, 31, 10, 20, 30, 0, 0, 100, 0));           // just clear
    pending_words.push_back(mk(0, 10, 32767, -32768, 32767, -32768, -32768, 32767, 32767));
    pending_words.push_back(mk(32767, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pending_words.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, 32767, -32768, 32767));
    pending_words.push_back(mk(3, 5, -32768, -32768, 32767, 0, 0, 1, 1));
    pending_words.push_back(mk(7, 3, 100, 100, 5, 0, 0, 10, 10));
    pending_words.push_back(mk(-1, 0, 32767, 32767, 1, 0, -1, 0, 1));
    drain();
    // Random phases with different idle and stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      repeat (240) pending_words.push_back(rnd_word());
      // Hold the sender once mid-phase until the pipeline empties
      if (phase == 3) begin
        while (pending_words.size() > 120) @(posedge clk);
        hold_off = 1;
        while (in_valid || expected_responses.size() != 0) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d result words, %0d with a collision response", checked, hits_seen);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
